### sv/mfq_pkg.sv
`timescale 1ns / 1ps
package mfq_pkg;

   localparam int LEVEL_COUNT_DEF  = 8;
   localparam int JOB_CAPACITY_DEF = 16;

   localparam int CMD_W      = 2;
   localparam int ID_W       = 6;
   localparam int LEVEL_W    = 4;
   localparam int LVL_INT_W  = 6;
   localparam int STATUS_W   = 2;
   localparam int SLICE_W    = 17;
   localparam int BASE_W     = 16;
   localparam int STEP_W     = 12;
   localparam int FRAC_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD,
      CMD_GET,
      CMD_BUMP,
      CMD_QUERY
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_BAD_LEVEL,
      STATUS_EMPTY
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SLICE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_STEP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUMP_FRACTION = 2'd2;

   localparam logic [FRAC_W-1:0] FRAC_FULL = 9'd256;

endpackage

### sv/mfq_if.sv
`timescale 1ns / 1ps
interface mfq_req_if;
   logic                          valid;
   logic                          ready;
   logic [mfq_pkg::CMD_W-1:0]     cmd;
   logic [mfq_pkg::ID_W-1:0]      job_id;
   logic signed [mfq_pkg::LEVEL_W-1:0] job_level;

   modport source (output valid, cmd, job_id, job_level, input ready);
   modport sink   (input valid, cmd, job_id, job_level, output ready);
endinterface

interface mfq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mfq_pkg::STATUS_W-1:0]   status;
   logic [mfq_pkg::ID_W-1:0]       out_job_id;
   logic signed [mfq_pkg::LEVEL_W-1:0] out_level;
   logic [mfq_pkg::SLICE_W-1:0]    time_slice;
   logic                           all_empty;

   modport source (output valid, status, out_job_id, out_level, time_slice, all_empty,
                   input ready);
   modport sink   (input valid, status, out_job_id, out_level, time_slice, all_empty,
                   output ready);
endinterface

interface mfq_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mfq_pkg::CSR_IDX_W-1:0]   index;
   logic [mfq_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/mfq_slice_unit.sv
`timescale 1ns / 1ps
module mfq_slice_unit (
   input  logic                               clock,
   input  logic                               load,
   input  logic [mfq_pkg::STEP_W-1:0]         step,
   input  logic signed [mfq_pkg::LVL_INT_W-1:0] level,
   input  logic [mfq_pkg::BASE_W-1:0]         base,
   output logic [mfq_pkg::SLICE_W-1:0]        slice
);

   logic [mfq_pkg::LVL_INT_W-2:0] lvl_mag;
   logic [mfq_pkg::SLICE_W-1:0]   prod_in;
   logic [mfq_pkg::SLICE_W-1:0]   prod_ff;

   // negative levels get the base slice only
   assign lvl_mag = (level > 0) ? level[mfq_pkg::LVL_INT_W-2:0] : '0;
   assign prod_in = mfq_pkg::SLICE_W'(step) * mfq_pkg::SLICE_W'(lvl_mag);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign slice = mfq_pkg::SLICE_W'(base) + prod_ff;

endmodule

### sv/multilevel_feedback_queue_core.sv
`timescale 1ns / 1ps
// Flow: an accepted word goes through S_EXEC, S_FINISH and S_SLICE, and rsp
// valid is registered from S_SLICE; get adds S_GET_WAIT after S_EXEC, and bump
// visits S_BUMP_SCAN per level from its start level up, and S_BUMP_MOVE per job
// moved to level 0, before S_FINISH. One word at a time: the sequencer and the
// single-port job store set the pace. A stalled rsp adds its stall.
// Reset (synchronous, active high) empties all queues and clears the
// configuration registers; the job store itself is not cleared.
module multilevel_feedback_queue_core #(
   parameter int LEVEL_COUNT  = mfq_pkg::LEVEL_COUNT_DEF,
   parameter int JOB_CAPACITY = mfq_pkg::JOB_CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mfq_req_if.sink    req_ch,
   mfq_rsp_if.source  rsp_ch,
   mfq_csr_if.sink    csr_ch
);

   localparam int LW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int LW1   = $clog2(LEVEL_COUNT + 1);
   localparam int PW    = $clog2(JOB_CAPACITY);
   localparam int CW    = $clog2(JOB_CAPACITY + 1);
   localparam int DEPTH = LEVEL_COUNT * JOB_CAPACITY;
   localparam int AW    = $clog2(DEPTH);
   localparam int BXW   = 14;
   localparam int IW    = mfq_pkg::LVL_INT_W;

   localparam logic signed [IW-1:0] LvlNone = -6'sd1;
   localparam logic signed [IW-1:0] LvlMax  = IW'(LEVEL_COUNT - 1);
   localparam logic [BXW-1:0]       BumpTop = BXW'((LEVEL_COUNT - 1) * 256);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_GET_WAIT,
      S_BUMP_SCAN,
      S_BUMP_MOVE,
      S_FINISH,
      S_SLICE
   } state_type;

   state_type state_ff, state_in;

   mfq_pkg::cmd_type                  cmd_ff, cmd_in;
   logic [mfq_pkg::ID_W-1:0]          id_ff, id_in;
   logic signed [mfq_pkg::LEVEL_W-1:0] lvl_ff, lvl_in;
   logic signed [IW-1:0]              out_lvl_ff, out_lvl_in;
   mfq_pkg::status_type               status_ff, status_in;
   logic [mfq_pkg::ID_W-1:0]          out_id_ff, out_id_in;
   logic [CW-1:0]                     total_ff, total_in;
   logic [PW-1:0]                     head_ff [LEVEL_COUNT];
   logic [PW-1:0]                     head_in [LEVEL_COUNT];
   logic [PW-1:0]                     tail_ff [LEVEL_COUNT];
   logic [PW-1:0]                     tail_in [LEVEL_COUNT];
   logic [CW-1:0]                     count_ff [LEVEL_COUNT];
   logic [CW-1:0]                     count_in [LEVEL_COUNT];
   logic [LW1-1:0]                    scan_ff, scan_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   mfq_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [mfq_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic signed [mfq_pkg::LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [mfq_pkg::SLICE_W-1:0]       rsp_slice_ff, rsp_slice_in;
   logic                              rsp_empty_ff, rsp_empty_in;

   logic [mfq_pkg::BASE_W-1:0]        base_ff, base_in;
   logic [mfq_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [mfq_pkg::FRAC_W-1:0]        frac_ff, frac_in;

   logic [mfq_pkg::ID_W-1:0]          mem [DEPTH];
   logic                              mem_we, mem_re;
   logic [AW-1:0]                     mem_waddr, mem_raddr;
   logic [mfq_pkg::ID_W-1:0]          mem_wdata;
   logic [mfq_pkg::ID_W-1:0]          rd_data_ff;

   logic signed [IW-1:0]              lvl_ext, next_lvl, start_ext;
   logic [LW-1:0]                     next_idx, get_idx, scan_idx;
   logic [mfq_pkg::FRAC_W-1:0]        frac_sat;
   logic [BXW-1:0]                    bump_lf;
   logic [LW1-1:0]                    bump_start;
   logic                              slice_load;
   logic [mfq_pkg::SLICE_W-1:0]       slice_val;

   function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
      return (p == PW'(JOB_CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [PW-1:0] p);
      return AW'(l) * AW'(JOB_CAPACITY) + AW'(p);
   endfunction

   assign lvl_ext  = {{(IW - mfq_pkg::LEVEL_W){lvl_ff[mfq_pkg::LEVEL_W-1]}}, lvl_ff};
   assign next_lvl = (lvl_ext == LvlMax) ? LvlMax : lvl_ext + signed'(IW'(1));
   assign next_idx = next_lvl[LW-1:0];
   assign scan_idx = scan_ff[LW-1:0];

   // bump start = floor(((L-1)*256 - L*f) / 256), clamped at zero
   assign frac_sat   = (frac_ff > mfq_pkg::FRAC_FULL) ? mfq_pkg::FRAC_FULL : frac_ff;
   assign bump_lf    = BXW'(LEVEL_COUNT) * BXW'(frac_sat);
   assign bump_start = (bump_lf >= BumpTop) ? '0 : LW1'((BumpTop - bump_lf) >> 8);
   assign start_ext  = IW'(bump_start);

   always_comb begin
      get_idx = '0;
      for (int k = LEVEL_COUNT - 1; k >= 0; k--) begin
         if (count_ff[k] != '0) get_idx = LW'(k);
      end
   end

   assign slice_load = (state_ff == S_FINISH);

   mfq_slice_unit u_slice (
      .clock (clock),
      .load  (slice_load),
      .step  (step_ff),
      .level (out_lvl_ff),
      .base  (base_ff),
      .slice (slice_val)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      lvl_in        = lvl_ff;
      out_lvl_in    = out_lvl_ff;
      status_in     = status_ff;
      out_id_in     = out_id_ff;
      total_in      = total_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_slice_in  = rsp_slice_ff;
      rsp_empty_in  = rsp_empty_ff;
      base_in       = base_ff;
      step_in       = step_ff;
      frac_in       = frac_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = '0;
      mem_raddr     = '0;
      mem_wdata     = id_ff;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            mfq_pkg::CSR_BASE_SLICE:    base_in = csr_ch.data[mfq_pkg::BASE_W-1:0];
            mfq_pkg::CSR_SLICE_STEP:    step_in = csr_ch.data[mfq_pkg::STEP_W-1:0];
            mfq_pkg::CSR_BUMP_FRACTION: frac_in = csr_ch.data[mfq_pkg::FRAC_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = mfq_pkg::cmd_type'(req_ch.cmd);
               id_in    = req_ch.job_id;
               lvl_in   = req_ch.job_level;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in  = mfq_pkg::STATUS_OK;
            out_id_in  = '0;
            out_lvl_in = lvl_ext;
            state_in   = S_FINISH;
            case (cmd_ff)
               mfq_pkg::CMD_ADD: begin
                  if (lvl_ext < LvlNone || lvl_ext > LvlMax) begin
                     status_in = mfq_pkg::STATUS_BAD_LEVEL;
                  end else if (total_ff >= CW'(JOB_CAPACITY)) begin
                     status_in = mfq_pkg::STATUS_FULL;
                  end else begin
                     mem_we             = 1'b1;
                     mem_waddr          = addr_of(next_idx, tail_ff[next_idx]);
                     mem_wdata          = id_ff;
                     tail_in[next_idx]  = pos_inc(tail_ff[next_idx]);
                     count_in[next_idx] = count_ff[next_idx] + 1'b1;
                     total_in           = total_ff + 1'b1;
                     out_lvl_in         = next_lvl;
                  end
               end
               mfq_pkg::CMD_GET: begin
                  if (total_ff == '0) begin
                     status_in  = mfq_pkg::STATUS_EMPTY;
                     out_lvl_in = LvlNone;
                  end else begin
                     mem_re            = 1'b1;
                     mem_raddr         = addr_of(get_idx, head_ff[get_idx]);
                     head_in[get_idx]  = pos_inc(head_ff[get_idx]);
                     count_in[get_idx] = count_ff[get_idx] - 1'b1;
                     total_in          = total_ff - 1'b1;
                     out_lvl_in        = IW'(get_idx);
                     state_in          = S_GET_WAIT;
                  end
               end
               mfq_pkg::CMD_BUMP: begin
                  if (lvl_ext >= start_ext) out_lvl_in = LvlNone;
                  scan_in  = (bump_start == '0) ? LW1'(1) : bump_start;
                  state_in = S_BUMP_SCAN;
               end
               default: ;
            endcase
         end
         S_GET_WAIT: begin
            out_id_in = rd_data_ff;
            state_in  = S_FINISH;
         end
         S_BUMP_SCAN: begin
            if (scan_ff >= LW1'(LEVEL_COUNT)) begin
               state_in = S_FINISH;
            end else if (count_ff[scan_idx] == '0) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               mem_re             = 1'b1;
               mem_raddr          = addr_of(scan_idx, head_ff[scan_idx]);
               head_in[scan_idx]  = pos_inc(head_ff[scan_idx]);
               count_in[scan_idx] = count_ff[scan_idx] - 1'b1;
               state_in           = S_BUMP_MOVE;
            end
         end
         S_BUMP_MOVE: begin
            mem_we      = 1'b1;
            mem_waddr   = addr_of('0, tail_ff[0]);
            mem_wdata   = rd_data_ff;
            tail_in[0]  = pos_inc(tail_ff[0]);
            count_in[0] = count_ff[0] + 1'b1;
            state_in    = S_BUMP_SCAN;
         end
         S_FINISH: begin
            state_in = S_SLICE;
         end
         S_SLICE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = out_id_ff;
               rsp_level_in  = out_lvl_ff[mfq_pkg::LEVEL_W-1:0];
               rsp_slice_in  = slice_val;
               rsp_empty_in  = (total_ff == '0);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         step_ff      <= '0;
         frac_ff      <= '0;
         for (int k = 0; k < LEVEL_COUNT; k++) begin
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            count_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         step_ff      <= step_in;
         frac_ff      <= frac_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      lvl_ff        <= lvl_in;
      out_lvl_ff    <= out_lvl_in;
      status_ff     <= status_in;
      out_id_ff     <= out_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_slice_ff  <= rsp_slice_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.out_job_id = rsp_id_ff;
   assign rsp_ch.out_level  = rsp_level_ff;
   assign rsp_ch.time_slice = rsp_slice_ff;
   assign rsp_ch.all_empty  = rsp_empty_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(JOB_CAPACITY))
      else $error("queued job total above capacity");

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("job store read and written in one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("ready while a word is in work");

   a_move_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUMP_MOVE) |-> $past(state_ff == S_BUMP_SCAN && mem_re))
      else $error("bump move without a pop");

   a_rsp_from_slice: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_SLICE))
      else $error("response raised outside slice step");

endmodule

### sim/mfq_shadow.sv
`timescale 1ns / 1ps
module mfq_shadow #(
   parameter int LEVEL_COUNT  = mfq_pkg::LEVEL_COUNT_DEF,
   parameter int JOB_CAPACITY = mfq_pkg::JOB_CAPACITY_DEF
) (
   input  logic clock,
   input  logic reset,
   mfq_req_if   req_ch,
   mfq_rsp_if   rsp_ch,
   mfq_csr_if   csr_ch,
   output int   fail_total,
   output int   words_due
);

   typedef struct packed {
      mfq_pkg::status_type                status;
      logic [mfq_pkg::ID_W-1:0]           job_id;
      logic signed [mfq_pkg::LEVEL_W-1:0] level;
      logic [mfq_pkg::SLICE_W-1:0]        slice;
      logic                               all_empty;
   } sched_word_type;

   logic [mfq_pkg::BASE_W-1:0] base_slice;
   logic [mfq_pkg::STEP_W-1:0] slice_step;
   logic [mfq_pkg::FRAC_W-1:0] bump_fraction;

   logic [mfq_pkg::ID_W-1:0] job_ring [LEVEL_COUNT][JOB_CAPACITY];
   int                       ring_head [LEVEL_COUNT];
   int                       ring_tail [LEVEL_COUNT];
   int                       ring_depth [LEVEL_COUNT];
   int                       queued_jobs;

   sched_word_type sched_results [$];
   sched_word_type got_word;
   sched_word_type want_word;
   int             fails = 0;
   int             lv;

   function automatic logic [mfq_pkg::SLICE_W-1:0] slice_for(int lvl);
      logic [mfq_pkg::SLICE_W-1:0] t;
      t = mfq_pkg::SLICE_W'(base_slice);
      if (lvl > 0) begin
         t = mfq_pkg::SLICE_W'(int'(base_slice) + int'(slice_step) * lvl);
      end
      return t;
   endfunction

   function automatic void push_job(int lvl, logic [mfq_pkg::ID_W-1:0] id);
      job_ring[lvl][ring_tail[lvl]] = id;
      ring_tail[lvl] = (ring_tail[lvl] + 1) % JOB_CAPACITY;
      ring_depth[lvl]++;
      queued_jobs++;
   endfunction

   function automatic logic [mfq_pkg::ID_W-1:0] pop_job(int lvl);
      logic [mfq_pkg::ID_W-1:0] id;
      id = job_ring[lvl][ring_head[lvl]];
      ring_head[lvl] = (ring_head[lvl] + 1) % JOB_CAPACITY;
      ring_depth[lvl]--;
      queued_jobs--;
      return id;
   endfunction

   function automatic sched_word_type run_cmd(mfq_pkg::cmd_type cmd,
                                              logic [mfq_pkg::ID_W-1:0] id, int lvl);
      sched_word_type w;
      int             out_lvl;
      int             frac;
      int             x;
      int             start;
      int             k;
      w.status = mfq_pkg::STATUS_OK;
      w.job_id = '0;
      out_lvl  = lvl;
      case (cmd)
         mfq_pkg::CMD_ADD: begin
            if (lvl < -1 || lvl > LEVEL_COUNT - 1) begin
               w.status = mfq_pkg::STATUS_BAD_LEVEL;
            end else if (queued_jobs >= JOB_CAPACITY) begin
               w.status = mfq_pkg::STATUS_FULL;
            end else begin
               out_lvl = (lvl == LEVEL_COUNT - 1) ? lvl : lvl + 1;
               push_job(out_lvl, id);
            end
         end
         mfq_pkg::CMD_GET: begin
            out_lvl  = -1;
            w.status = mfq_pkg::STATUS_EMPTY;
            for (k = 0; k < LEVEL_COUNT && w.status == mfq_pkg::STATUS_EMPTY; k++) begin
               if (ring_depth[k] > 0) begin
                  w.job_id = pop_job(k);
                  out_lvl  = k;
                  w.status = mfq_pkg::STATUS_OK;
               end
            end
         end
         mfq_pkg::CMD_BUMP: begin
            frac  = (bump_fraction > mfq_pkg::FRAC_FULL) ? int'(mfq_pkg::FRAC_FULL) :
                    int'(bump_fraction);
            x     = (LEVEL_COUNT - 1) * 256 - LEVEL_COUNT * frac;
            start = (x <= 0) ? 0 : x / 256;
            if (lvl >= start) begin
               out_lvl = -1;
            end
            for (k = (start < 1) ? 1 : start; k < LEVEL_COUNT; k++) begin
               while (ring_depth[k] > 0) begin
                  push_job(0, pop_job(k));
               end
            end
         end
         default: ;
      endcase
      w.level     = out_lvl[mfq_pkg::LEVEL_W-1:0];
      w.slice     = slice_for(out_lvl);
      w.all_empty = (queued_jobs == 0);
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         base_slice    = '0;
         slice_step    = '0;
         bump_fraction = '0;
         queued_jobs   = 0;
         for (lv = 0; lv < LEVEL_COUNT; lv++) begin
            ring_head[lv]  = 0;
            ring_tail[lv]  = 0;
            ring_depth[lv] = 0;
         end
         sched_results.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               mfq_pkg::CSR_BASE_SLICE:    base_slice    = csr_ch.data[mfq_pkg::BASE_W-1:0];
               mfq_pkg::CSR_SLICE_STEP:    slice_step    = csr_ch.data[mfq_pkg::STEP_W-1:0];
               mfq_pkg::CSR_BUMP_FRACTION: bump_fraction = csr_ch.data[mfq_pkg::FRAC_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            sched_results.push_back(run_cmd(mfq_pkg::cmd_type'(req_ch.cmd), req_ch.job_id,
                                            req_ch.job_level));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_word.status    = mfq_pkg::status_type'(rsp_ch.status);
            got_word.job_id    = rsp_ch.out_job_id;
            got_word.level     = rsp_ch.out_level;
            got_word.slice     = rsp_ch.time_slice;
            got_word.all_empty = rsp_ch.all_empty;
            if (sched_results.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("unexpected rsp word: status %0d id %0d level %0d slice %0d empty %0d",
                           got_word.status, got_word.job_id, got_word.level,
                           got_word.slice, got_word.all_empty);
               end
            end else begin
               want_word = sched_results.pop_front();
               if (got_word.status !== want_word.status || got_word.job_id !== want_word.job_id ||
                   got_word.level !== want_word.level || got_word.slice !== want_word.slice ||
                   got_word.all_empty !== want_word.all_empty) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("rsp mismatch (exp/got): status %0d/%0d id %0d/%0d level %0d/%0d",
                              want_word.status, got_word.status, want_word.job_id,
                              got_word.job_id, want_word.level, got_word.level);
                     $display("   slice %0d/%0d empty %0d/%0d", want_word.slice,
                              got_word.slice, want_word.all_empty, got_word.all_empty);
                  end
               end
            end
         end
      end
      fail_total <= fails;
      words_due  <= sched_results.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 195;

   logic clock;
   logic reset;

   mfq_req_if req_ch ();
   mfq_rsp_if rsp_ch ();
   mfq_csr_if csr_ch ();

   int fail_total;
   int words_due;
   bit calm;
   int idle_cycles;
   int phase;
   int n;
   int mode;

   multilevel_feedback_queue_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   mfq_shadow shadow (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_total (fail_total),
      .words_due  (words_due)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= calm || ($urandom_range(99) >= 17);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb NOT OK");
      $finish;
   end

   task automatic send_cmd(mfq_pkg::cmd_type cmd, logic [mfq_pkg::ID_W-1:0] id,
                           logic signed [mfq_pkg::LEVEL_W-1:0] lvl);
      if (!calm && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.job_id    <= id;
      req_ch.job_level <= lvl;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic program_regs(logic [mfq_pkg::CSR_DATA_W-1:0] base,
                               logic [mfq_pkg::CSR_DATA_W-1:0] step_word,
                               logic [mfq_pkg::CSR_DATA_W-1:0] frac_word);
      logic [mfq_pkg::CSR_IDX_W-1:0]  idx [3];
      logic [mfq_pkg::CSR_DATA_W-1:0] val [3];
      idx = '{mfq_pkg::CSR_BASE_SLICE, mfq_pkg::CSR_SLICE_STEP, mfq_pkg::CSR_BUMP_FRACTION};
      val = '{base, step_word, frac_word};
      for (int i = 0; i < 3; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.data  <= val[i];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   // mode 0 fills the queues, 1 drains them, 2 mixes
   task automatic random_cmd(int fill_mode);
      int                                 r;
      int                                 pick;
      mfq_pkg::cmd_type                   c;
      logic signed [mfq_pkg::LEVEL_W-1:0] lvl;
      r = $urandom_range(99);
      case (fill_mode)
         0:       c = (r < 60) ? mfq_pkg::CMD_ADD : (r < 75) ? mfq_pkg::CMD_GET :
                      (r < 88) ? mfq_pkg::CMD_BUMP : mfq_pkg::CMD_QUERY;
         1:       c = (r < 20) ? mfq_pkg::CMD_ADD : (r < 75) ? mfq_pkg::CMD_GET :
                      (r < 87) ? mfq_pkg::CMD_BUMP : mfq_pkg::CMD_QUERY;
         default: c = (r < 42) ? mfq_pkg::CMD_ADD : (r < 77) ? mfq_pkg::CMD_GET :
                      (r < 89) ? mfq_pkg::CMD_BUMP : mfq_pkg::CMD_QUERY;
      endcase
      if ($urandom_range(99) < 8) begin
         lvl = mfq_pkg::LEVEL_W'($urandom_range(15));
      end else begin
         pick = int'($urandom_range(8)) - 1;
         lvl  = pick[mfq_pkg::LEVEL_W-1:0];
      end
      send_cmd(c, mfq_pkg::ID_W'($urandom_range(63)), lvl);
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.cmd       <= mfq_pkg::CMD_ADD;
      req_ch.job_id    <= '0;
      req_ch.job_level <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= mfq_pkg::CSR_BASE_SLICE;
      csr_ch.data      <= '0;
      calm = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      program_regs(16'd100, 16'd7, 16'd128);
      send_cmd(mfq_pkg::CMD_GET, 6'd0, -4'sd1);
      send_cmd(mfq_pkg::CMD_QUERY, 6'd63, 4'sb1000);
      send_cmd(mfq_pkg::CMD_QUERY, 6'd0, 4'sd7);
      send_cmd(mfq_pkg::CMD_QUERY, 6'd0, -4'sd1);
      send_cmd(mfq_pkg::CMD_ADD, 6'd5, 4'sb1000);
      send_cmd(mfq_pkg::CMD_ADD, 6'd6, -4'sd2);
      for (n = 0; n < 16; n++) begin
         send_cmd(mfq_pkg::CMD_ADD, (n == 15) ? 6'd63 : mfq_pkg::ID_W'(n * 4),
                  mfq_pkg::LEVEL_W'(n % 9 - 1));
      end
      send_cmd(mfq_pkg::CMD_ADD, 6'd21, 4'sd3);
      send_cmd(mfq_pkg::CMD_BUMP, 6'd0, 4'sd5);
      send_cmd(mfq_pkg::CMD_BUMP, 6'd0, 4'sb1000);
      send_cmd(mfq_pkg::CMD_GET, 6'd0, 4'sd0);
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       program_regs(16'd0, 16'd0, 16'd0);
            1:       program_regs(16'hFFFF, 16'h0FFF, 16'd256);
            2:       program_regs(16'hFFFF, 16'hF000, 16'h01FF);
            3:       program_regs(16'd0, 16'hFFFF, 16'hFE20);
            default: program_regs(mfq_pkg::CSR_DATA_W'($urandom),
                                  mfq_pkg::CSR_DATA_W'($urandom),
                                  ($urandom_range(99) < 20) ? mfq_pkg::CSR_DATA_W'($urandom) :
                                  mfq_pkg::CSR_DATA_W'(($urandom & 32'hFE00) |
                                                       $urandom_range(256)));
         endcase
         calm = (phase == 5);
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0) begin
               mode = $urandom_range(2);
            end
            random_cmd(mode);
         end
         drain();
      end

      repeat (64) @(posedge clock);
      if (fail_total == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
sv/mfq_pkg.sv
sv/mfq_if.sv
sv/mfq_slice_unit.sv
sv/multilevel_feedback_queue_core.sv
sim/mfq_shadow.sv
sim/tb.sv
